[rtl/als_pkg.sv]
// ----------------------------------------------------------------------------
// als_pkg: shared types for the array list store
// Command and status encodings used on the command and result ports.
// ----------------------------------------------------------------------------
package als_pkg;

    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned LENGTH_W = 9;
    localparam int unsigned STATUS_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_GET     = 3'd0,
        FN_SET     = 3'd1,
        FN_FIND    = 3'd2,
        FN_APPEND  = 3'd3,
        FN_INSERT  = 3'd4,
        FN_FRONT   = 3'd5,
        FN_BACK    = 3'd6,
        FN_RESTART = 3'd7
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_RANGE = 3'd1,
        ST_FULL  = 3'd2,
        ST_EMPTY = 3'd3,
        ST_MISS  = 3'd4
    } t_status;

endpackage

[rtl/array_list_store.sv]
// ----------------------------------------------------------------------------
// array_list_store: ordered list of signed 32-bit values
// A command is taken when start is high and busy is low. Commands: get, set,
// find, append, insert, front, back and restart. Every command produces one
// result, shown on the o_ result ports for one cycle while o_result_valid is
// high; the receiver always takes it and cannot stall the block.
// Entries live in a single-port-write, single-port-read memory of DEPTH words
// with a registered read.
// How each command completes:
//   set, append and every range, full or empty error: busy stays low
//   get, front, back: a registered memory read, then S_RD_WAIT
//   find: one entry compared per cycle, stopping at the first match
//   insert: one entry shifted per cycle, from the back down to the index
//   restart: one entry cleared per cycle
// The memory's one write port sets the pace of insert and restart, its one
// read port that of find. The next command may be given in the cycle in
// which the result strobe is high.
// The restart length register is written through i_cfg_we/i_cfg_wdata; the user
// must do so only while the block is idle; the block does not enforce it. Reset
// empties the list and clears that register; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module array_list_store #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [als_pkg::LENGTH_W-1:0]  i_cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic [als_pkg::FUNC_W-1:0]    i_func,
    input  logic [als_pkg::INDEX_W-1:0]   i_index,
    input  logic signed [als_pkg::DATA_W-1:0] i_data_in,
    output logic                          o_result_valid,
    output logic signed [als_pkg::DATA_W-1:0] o_data_out,
    output logic [als_pkg::INDEX_W-1:0]   o_position,
    output logic [als_pkg::LENGTH_W-1:0]  o_length,
    output logic [als_pkg::STATUS_W-1:0]  o_status
);

    localparam int unsigned AW     = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned WIDE_W = (CNT_W > als_pkg::LENGTH_W) ? CNT_W : als_pkg::LENGTH_W;
    localparam int unsigned PW     = (AW > als_pkg::INDEX_W) ? AW : als_pkg::INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_FIND,
        S_INS,
        S_INS_LAST,
        S_ZERO
    } t_state;

    t_state                         r_state;
    logic [CNT_W-1:0]               r_count;
    logic [als_pkg::LENGTH_W-1:0]   r_init_len;
    logic [CNT_W-1:0]               r_ptr;
    logic                           r_more;
    logic                           r_rd_vld;
    logic [AW-1:0]                  r_rd_addr;
    logic [AW-1:0]                  r_idx;
    logic [als_pkg::DATA_W-1:0]     r_val;
    logic [als_pkg::DATA_W-1:0]     r_rdata;
    logic [als_pkg::DATA_W-1:0]     r_mem [DEPTH];

    logic                           accept;
    als_pkg::t_func                 func;
    logic [WIDE_W-1:0]              idx_w;
    logic [WIDE_W-1:0]              cnt_w;
    logic [WIDE_W-1:0]              inc_w;
    logic [WIDE_W-1:0]              rst_len_w;
    logic [PW-1:0]                  pos_w;
    logic [CNT_W-1:0]               cnt_m1;
    logic [CNT_W-1:0]               rst_len;
    logic                           idx_ok;
    logic                           full;
    logic                           empty;
    logic                           find_issue;
    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [als_pkg::DATA_W-1:0]     mem_wdata;
    logic                           mem_re;
    logic [AW-1:0]                  mem_raddr;

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && (r_state == S_IDLE);
    assign func       = als_pkg::t_func'(i_func);
    assign idx_w      = WIDE_W'(i_index);
    assign cnt_w      = WIDE_W'(r_count);
    assign inc_w      = WIDE_W'(r_count + CNT_W'(1));
    assign cnt_m1     = r_count - CNT_W'(1);
    assign idx_ok     = (idx_w < cnt_w);
    assign full       = (r_count == CNT_W'(DEPTH));
    assign empty      = (r_count == '0);
    assign find_issue = (r_ptr < r_count);
    assign pos_w      = PW'(r_rd_addr);

    // An oversized restart length saturates to the capacity.
    always_comb begin
        if (WIDE_W'(r_init_len) > WIDE_W'(DEPTH)) begin
            rst_len = CNT_W'(DEPTH);
        end else begin
            rst_len = CNT_W'(r_init_len);
        end
    end
    assign rst_len_w = WIDE_W'(rst_len);

    // Memory port control.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = i_data_in;
        mem_re    = 1'b0;
        mem_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (func)
                        als_pkg::FN_GET: begin
                            mem_re    = idx_ok;
                            mem_raddr = idx_w[AW-1:0];
                        end
                        als_pkg::FN_SET: begin
                            mem_we    = idx_ok;
                            mem_waddr = idx_w[AW-1:0];
                        end
                        als_pkg::FN_APPEND: begin
                            mem_we    = !full;
                            mem_waddr = r_count[AW-1:0];
                        end
                        als_pkg::FN_FRONT: begin
                            mem_re    = !empty;
                            mem_raddr = '0;
                        end
                        als_pkg::FN_BACK: begin
                            mem_re    = !empty;
                            mem_raddr = cnt_m1[AW-1:0];
                        end
                        als_pkg::FN_FIND,
                        als_pkg::FN_INSERT,
                        als_pkg::FN_RESTART: begin
                            mem_re = 1'b0;
                        end
                    endcase
                end
            end
            S_FIND: begin
                mem_re    = find_issue;
                mem_raddr = r_ptr[AW-1:0];
            end
            S_INS: begin
                // Read entry j while writing entry j+1's value into j+2.
                mem_re    = r_more;
                mem_raddr = r_ptr[AW-1:0];
                mem_we    = r_rd_vld;
                mem_waddr = r_rd_addr + AW'(1);
                mem_wdata = r_rdata;
            end
            S_INS_LAST: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_val;
            end
            S_ZERO: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[AW-1:0];
                mem_wdata = '0;
            end
            S_RD_WAIT: begin
                mem_re = 1'b0;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Control state and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_init_len     <= '0;
            r_ptr          <= '0;
            r_more         <= 1'b0;
            r_rd_vld       <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            if (i_cfg_we) begin
                r_init_len <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_val      <= i_data_in;
                        r_idx      <= idx_w[AW-1:0];
                        o_data_out <= '0;
                        o_position <= '0;
                        o_length   <= cnt_w[als_pkg::LENGTH_W-1:0];
                        o_status   <= als_pkg::ST_OK;
                        unique case (func)
                            als_pkg::FN_GET: begin
                                if (idx_ok) begin
                                    r_state <= S_RD_WAIT;
                                end else begin
                                    o_result_valid <= 1'b1;
                                    o_status       <= als_pkg::ST_RANGE;
                                end
                            end
                            als_pkg::FN_SET: begin
                                o_result_valid <= 1'b1;
                                if (!idx_ok) begin
                                    o_status <= als_pkg::ST_RANGE;
                                end
                            end
                            als_pkg::FN_FIND: begin
                                r_ptr    <= '0;
                                r_rd_vld <= 1'b0;
                                r_state  <= S_FIND;
                            end
                            als_pkg::FN_APPEND: begin
                                o_result_valid <= 1'b1;
                                if (full) begin
                                    o_status <= als_pkg::ST_FULL;
                                end else begin
                                    r_count  <= r_count + CNT_W'(1);
                                    o_length <= inc_w[als_pkg::LENGTH_W-1:0];
                                end
                            end
                            als_pkg::FN_INSERT: begin
                                if (!idx_ok) begin
                                    o_result_valid <= 1'b1;
                                    o_status       <= als_pkg::ST_RANGE;
                                end else if (full) begin
                                    o_result_valid <= 1'b1;
                                    o_status       <= als_pkg::ST_FULL;
                                end else begin
                                    r_ptr    <= cnt_m1;
                                    r_more   <= 1'b1;
                                    r_rd_vld <= 1'b0;
                                    r_state  <= S_INS;
                                end
                            end
                            als_pkg::FN_FRONT,
                            als_pkg::FN_BACK: begin
                                if (empty) begin
                                    o_result_valid <= 1'b1;
                                    o_status       <= als_pkg::ST_EMPTY;
                                end else begin
                                    r_state <= S_RD_WAIT;
                                end
                            end
                            als_pkg::FN_RESTART: begin
                                r_count  <= rst_len;
                                o_length <= rst_len_w[als_pkg::LENGTH_W-1:0];
                                if (rst_len == '0) begin
                                    o_result_valid <= 1'b1;
                                end else begin
                                    r_ptr   <= '0;
                                    r_state <= S_ZERO;
                                end
                            end
                        endcase
                    end
                end
                S_RD_WAIT: begin
                    o_result_valid <= 1'b1;
                    o_data_out     <= r_rdata;
                    r_state        <= S_IDLE;
                end
                S_FIND: begin
                    r_rd_vld  <= find_issue;
                    r_rd_addr <= r_ptr[AW-1:0];
                    if (find_issue) begin
                        r_ptr <= r_ptr + CNT_W'(1);
                    end
                    if (r_rd_vld && (r_rdata == r_val)) begin
                        o_result_valid <= 1'b1;
                        o_position     <= pos_w[als_pkg::INDEX_W-1:0];
                        r_rd_vld       <= 1'b0;
                        r_state        <= S_IDLE;
                    end else if (!find_issue && !r_rd_vld) begin
                        o_result_valid <= 1'b1;
                        o_status       <= als_pkg::ST_MISS;
                        r_state        <= S_IDLE;
                    end
                end
                S_INS: begin
                    r_rd_vld  <= r_more;
                    r_rd_addr <= r_ptr[AW-1:0];
                    if (r_more) begin
                        if (r_ptr[AW-1:0] == r_idx) begin
                            r_more <= 1'b0;
                        end else begin
                            r_ptr <= r_ptr - CNT_W'(1);
                        end
                    end
                    if (!r_more && !r_rd_vld) begin
                        r_state <= S_INS_LAST;
                    end
                end
                S_INS_LAST: begin
                    r_count        <= r_count + CNT_W'(1);
                    o_length       <= inc_w[als_pkg::LENGTH_W-1:0];
                    o_result_valid <= 1'b1;
                    r_state        <= S_IDLE;
                end
                S_ZERO: begin
                    r_ptr <= r_ptr + CNT_W'(1);
                    if (r_ptr == cnt_m1) begin
                        o_result_valid <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The list never grows past its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WIDE_W'(r_count) <= WIDE_W'(DEPTH))
        else $error("list length exceeds capacity");

    // A result only follows a command transfer or an active command.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(accept) || ($past(r_state) != S_IDLE)))
        else $error("result without a command");

    // The shift of an insert never reads the entry it writes in that cycle.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same entry");

    // The length holds steady while entries are being shifted.
    a_ins_len_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |=> (r_count == $past(r_count)))
        else $error("length changed during insert shift");

    // Any failing command reports zero data.
    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status != als_pkg::ST_OK)) |-> (o_data_out == '0))
        else $error("error result carries data");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the array list store
// Commands go out from a queue through a clocked driver, and a shadow copy of
// the list predicts every result. A clocked monitor compares each result
// strobe field by field against the oldest prediction. Phases vary the
// restart length and the sender's idle rate.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned LIST_DEPTH  = 256;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int unsigned DRAIN_WAIT  = 300;

    typedef struct {
        als_pkg::t_func                    func;
        logic [als_pkg::INDEX_W-1:0]       index;
        logic signed [als_pkg::DATA_W-1:0] data_in;
    } t_list_cmd;

    typedef struct {
        logic signed [als_pkg::DATA_W-1:0] data_out;
        logic [als_pkg::INDEX_W-1:0]       position;
        logic [als_pkg::LENGTH_W-1:0]      length;
        als_pkg::t_status                  status;
        longint unsigned                   accepted_at;
    } t_list_result;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [als_pkg::LENGTH_W-1:0]      i_cfg_wdata = '0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [als_pkg::FUNC_W-1:0]        i_func = '0;
    logic [als_pkg::INDEX_W-1:0]       i_index = '0;
    logic signed [als_pkg::DATA_W-1:0] i_data_in = '0;
    logic                              o_result_valid;
    logic signed [als_pkg::DATA_W-1:0] o_data_out;
    logic [als_pkg::INDEX_W-1:0]       o_position;
    logic [als_pkg::LENGTH_W-1:0]      o_length;
    logic [als_pkg::STATUS_W-1:0]      o_status;

    array_list_store #(
        .DEPTH(LIST_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_index        (i_index),
        .i_data_in      (i_data_in),
        .o_result_valid (o_result_valid),
        .o_data_out     (o_data_out),
        .o_position     (o_position),
        .o_length       (o_length),
        .o_status       (o_status)
    );

    // Shadow copy of the list and its restart length.
    logic signed [als_pkg::DATA_W-1:0] shadow_entries [LIST_DEPTH];
    int unsigned                       shadow_count = 0;
    logic [als_pkg::LENGTH_W-1:0]      shadow_restart_len = '0;

    t_list_cmd                pending_cmds[$];
    t_list_result             predicted_results[$];
    t_list_cmd                on_port;
    int unsigned              in_flight = 0;
    int unsigned              sender_idle_pct = 0;
    logic                     hold_for_results = 1'b0;
    int unsigned              error_count = 0;
    int unsigned              cycle_count = 0;

    // Stimulus planning: the length the list will have once all queued
    // commands have run, and a pool of stored values so that searches hit.
    int unsigned                       planned_len = 0;
    logic signed [als_pkg::DATA_W-1:0] value_pool[$];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_list_result apply_list_command(t_list_cmd c);
        t_list_result r;
        int unsigned  i;
        logic         hit;
        r.data_out    = '0;
        r.position    = '0;
        r.status      = als_pkg::ST_OK;
        r.accepted_at = 0;
        hit           = 1'b0;
        case (c.func)
            als_pkg::FN_GET: begin
                if (c.index < shadow_count) r.data_out = shadow_entries[c.index];
                else r.status = als_pkg::ST_RANGE;
            end
            als_pkg::FN_SET: begin
                if (c.index < shadow_count) shadow_entries[c.index] = c.data_in;
                else r.status = als_pkg::ST_RANGE;
            end
            als_pkg::FN_FIND: begin
                r.status = als_pkg::ST_MISS;
                for (i = 0; i < shadow_count && !hit; i++) begin
                    if (shadow_entries[i] == c.data_in) begin
                        hit        = 1'b1;
                        r.position = i[als_pkg::INDEX_W-1:0];
                        r.status   = als_pkg::ST_OK;
                    end
                end
            end
            als_pkg::FN_APPEND: begin
                if (shadow_count >= LIST_DEPTH) begin
                    r.status = als_pkg::ST_FULL;
                end else begin
                    shadow_entries[shadow_count] = c.data_in;
                    shadow_count++;
                end
            end
            als_pkg::FN_INSERT: begin
                if (c.index >= shadow_count) begin
                    r.status = als_pkg::ST_RANGE;
                end else if (shadow_count >= LIST_DEPTH) begin
                    r.status = als_pkg::ST_FULL;
                end else begin
                    for (i = shadow_count; i > c.index; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[c.index] = c.data_in;
                    shadow_count++;
                end
            end
            als_pkg::FN_FRONT: begin
                if (shadow_count == 0) r.status = als_pkg::ST_EMPTY;
                else r.data_out = shadow_entries[0];
            end
            als_pkg::FN_BACK: begin
                if (shadow_count == 0) r.status = als_pkg::ST_EMPTY;
                else r.data_out = shadow_entries[shadow_count-1];
            end
            als_pkg::FN_RESTART: begin
                shadow_count = (shadow_restart_len > LIST_DEPTH) ? LIST_DEPTH
                                                                  : shadow_restart_len;
                for (i = 0; i < shadow_count; i++)
                    shadow_entries[i] = '0;
            end
        endcase
        r.length = shadow_count[als_pkg::LENGTH_W-1:0];
        return r;
    endfunction

    task automatic flag_error(string msg);
        error_count++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Queues one command and keeps the planned length in step with it.
    task automatic queue_cmd(als_pkg::t_func f, int unsigned idx,
                             logic signed [als_pkg::DATA_W-1:0] d);
        t_list_cmd c;
        c.func    = f;
        c.index   = idx[als_pkg::INDEX_W-1:0];
        c.data_in = d;
        pending_cmds.push_back(c);
        case (f)
            als_pkg::FN_APPEND: if (planned_len < LIST_DEPTH) planned_len++;
            als_pkg::FN_INSERT:
                if (c.index < planned_len && planned_len < LIST_DEPTH) planned_len++;
            als_pkg::FN_RESTART:
                planned_len = (shadow_restart_len > LIST_DEPTH) ? LIST_DEPTH
                                                                : shadow_restart_len;
            default: ;
        endcase
        if (f == als_pkg::FN_APPEND || f == als_pkg::FN_INSERT || f == als_pkg::FN_SET) begin
            value_pool.push_back(d);
            if (value_pool.size() > 16) void'(value_pool.pop_front());
        end
    endtask

    function automatic logic signed [als_pkg::DATA_W-1:0] pick_value(int unsigned pool_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < pool_pct && value_pool.size() != 0)
            return value_pool[$urandom_range(value_pool.size()-1)];
        if (r < pool_pct + 10) begin
            case ($urandom_range(3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic queue_random_cmds(int unsigned count);
        int unsigned n;
        int unsigned sel;
        int unsigned idx;
        for (n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (planned_len > 0 && $urandom_range(9) < 8)
                idx = $urandom_range(planned_len-1);
            else
                idx = $urandom_range(255);
            if (sel < 25)      queue_cmd(als_pkg::FN_APPEND, idx, pick_value(20));
            else if (sel < 40) queue_cmd(als_pkg::FN_INSERT, idx, pick_value(20));
            else if (sel < 55) queue_cmd(als_pkg::FN_GET, idx, pick_value(0));
            else if (sel < 67) queue_cmd(als_pkg::FN_SET, idx, pick_value(20));
            else if (sel < 80) queue_cmd(als_pkg::FN_FIND, idx, pick_value(70));
            else if (sel < 85) queue_cmd(als_pkg::FN_FRONT, idx, pick_value(0));
            else if (sel < 90) queue_cmd(als_pkg::FN_BACK, idx, pick_value(0));
            else if (sel < 93) queue_cmd(als_pkg::FN_RESTART, idx, pick_value(0));
            else queue_cmd(als_pkg::t_func'($urandom_range(7)), $urandom_range(255),
                           $urandom);
        end
    endtask

    task automatic wait_until_idle();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || start || predicted_results.size() != 0);
    endtask

    task automatic write_restart_len(logic [als_pkg::LENGTH_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we           <= 1'b1;
        i_cfg_wdata        <= value;
        shadow_restart_len  = value;
        @(posedge i_clk);
        i_cfg_we           <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_random_phase(int unsigned idle_pct, logic lockstep,
                                    int unsigned count);
        sender_idle_pct  = idle_pct;
        hold_for_results = lockstep;
        queue_random_cmds(count);
        wait_until_idle();
    endtask

    // Driver: a transfer happens on an edge where start is high and busy is
    // low; the prediction is made at that edge.
    always @(posedge i_clk) begin : drive_commands
        logic         took;
        t_list_result predicted;
        took = start && !busy;
        if (!i_rst_n) begin
            start     <= 1'b0;
            in_flight  = 0;
        end else begin
            if (took) begin
                predicted             = apply_list_command(on_port);
                predicted.accepted_at = $time;
                predicted_results.push_back(predicted);
                in_flight++;
            end
            if (o_result_valid && in_flight > 0)
                in_flight--;
            if (start && !took) begin
                // Hold the command on the ports until the block takes it.
            end else if (pending_cmds.size() != 0 &&
                         !(hold_for_results && in_flight != 0) &&
                         $urandom_range(99) >= sender_idle_pct) begin
                on_port    = pending_cmds.pop_front();
                start     <= 1'b1;
                i_func    <= on_port.func;
                i_index   <= on_port.index;
                i_data_in <= on_port.data_in;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: a prediction only counts if it was made at an earlier edge.
    always @(posedge i_clk) begin : check_results
        t_list_result want;
        if (i_rst_n && o_result_valid) begin
            if (predicted_results.size() == 0 ||
                predicted_results[0].accepted_at >= $time) begin
                flag_error("result strobe with no command outstanding");
            end else begin
                want = predicted_results.pop_front();
                if (o_data_out !== want.data_out)
                    flag_error($sformatf("data_out %0d, expected %0d",
                                         o_data_out, want.data_out));
                if (o_position !== want.position)
                    flag_error($sformatf("position %0d, expected %0d",
                                         o_position, want.position));
                if (o_length !== want.length)
                    flag_error($sformatf("length %0d, expected %0d",
                                         o_length, want.length));
                if (o_status !== want.status)
                    flag_error($sformatf("status %0d, expected %s",
                                         o_status, want.status.name()));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_restart_len(9'd0);

        // Empty list, the value extremes, every command but restart with its range, empty and miss errors.
        queue_cmd(als_pkg::FN_FRONT, 0, 0);
        queue_cmd(als_pkg::FN_BACK, 0, 0);
        queue_cmd(als_pkg::FN_GET, 0, 0);
        queue_cmd(als_pkg::FN_SET, 0, 1);
        queue_cmd(als_pkg::FN_INSERT, 0, 2);
        queue_cmd(als_pkg::FN_FIND, 0, 0);
        queue_cmd(als_pkg::FN_APPEND, 0, 32'sh8000_0000);
        queue_cmd(als_pkg::FN_APPEND, 0, 32'sh7FFF_FFFF);
        queue_cmd(als_pkg::FN_APPEND, 0, -32'sd1);
        queue_cmd(als_pkg::FN_APPEND, 0, 32'sd0);
        queue_cmd(als_pkg::FN_GET, 0, 0);
        queue_cmd(als_pkg::FN_GET, 4, 0);
        queue_cmd(als_pkg::FN_GET, 255, 0);
        queue_cmd(als_pkg::FN_SET, 1, 32'sh1234_5678);
        queue_cmd(als_pkg::FN_INSERT, 0, 32'sd5);
        queue_cmd(als_pkg::FN_INSERT, 4, -32'sd7);
        queue_cmd(als_pkg::FN_INSERT, 6, 32'sd9);
        queue_cmd(als_pkg::FN_FIND, 0, 32'sh8000_0000);
        queue_cmd(als_pkg::FN_FIND, 0, 32'sh0BAD_F00D);
        queue_cmd(als_pkg::FN_FRONT, 0, 0);
        queue_cmd(als_pkg::FN_BACK, 0, 0);
        wait_until_idle();

        // A full list: append and insert are refused, the last entry is found.
        write_restart_len(9'd256);
        queue_cmd(als_pkg::FN_RESTART, 0, 0);
        queue_cmd(als_pkg::FN_APPEND, 0, 32'sd1);
        queue_cmd(als_pkg::FN_INSERT, 255, 32'sd2);
        queue_cmd(als_pkg::FN_SET, 255, 32'sh7FFF_FFFF);
        queue_cmd(als_pkg::FN_GET, 255, 0);
        queue_cmd(als_pkg::FN_FIND, 0, 32'sh7FFF_FFFF);
        queue_cmd(als_pkg::FN_BACK, 0, 0);
        wait_until_idle();

        write_restart_len(9'd511);
        run_random_phase(0, 1'b0, 150);
        write_restart_len(9'd1);
        run_random_phase(58, 1'b0, 150);
        write_restart_len(9'd255);
        run_random_phase(10, 1'b0, 150);
        write_restart_len(als_pkg::LENGTH_W'($urandom_range(511)));
        run_random_phase(58, 1'b1, 100);
        write_restart_len(9'd256);
        run_random_phase(0, 1'b0, 200);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0 && predicted_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[array_list_store.f]
rtl/als_pkg.sv
rtl/array_list_store.sv
test/testbench.sv
